### rtl/core/hdtc_pkg.sv
// hdtc_pkg: types and constants shared by the handheld timer core.
// Transaction structs, command and register select codes, counter period masks.
// No dependencies.
package hdtc_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] SEL_DIVIDER = 2'd0;
  localparam logic [1:0] SEL_COUNTER = 2'd1;
  localparam logic [1:0] SEL_MODULO  = 2'd2;
  localparam logic [1:0] SEL_CONTROL = 2'd3;

  localparam int unsigned CTRL_ENABLE_BIT = 2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] cycle_index;
    logic [1:0] reg_select;
    logic [7:0] write_data;
  } hdtc_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } hdtc_out_t;

  // counter period minus one, by control bits 1..0
  function automatic logic [7:0] period_mask(input logic [1:0] rate);
    logic [7:0] m;
    begin
      case (rate)
        2'd0:    m = 8'hFF;
        2'd1:    m = 8'h03;
        2'd2:    m = 8'h0F;
        default: m = 8'h3F;
      endcase
      return m;
    end
  endfunction

endpackage

### rtl/core/handheld_timer_divider_counter_core.sv
// Handheld timer core top level: input register, timer update, result register.
// One transaction in, one result transaction out, in order.
// Depends on hdtc_pkg and hdtc_timer.
//
// Accepts one tick, register write or register read every clock cycle and
// returns exactly one result transaction for each, in order. An accepted
// transaction waits in the input register, then passes through the timer
// update into the result register. Throughput is one transaction per cycle;
// it drops only while out_stall holds the result register.
module handheld_timer_divider_counter_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hdtc_pkg::hdtc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hdtc_pkg::hdtc_out_t out_data
);

  logic                s1_valid_r;
  hdtc_pkg::hdtc_in_t  s1_data_r;
  logic                out_valid_r;
  hdtc_pkg::hdtc_out_t out_data_r;
  hdtc_pkg::hdtc_out_t res;
  logic                out_free;
  logic                s1_adv;
  logic                in_acc;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  hdtc_timer u_timer (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .item   (s1_data_r),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/hdtc_timer.sv
// hdtc_timer: timer register file and single-pass update logic.
// Holds divider, counter, modulo, control, overflow and reload flags.
// Depends on hdtc_pkg.
module hdtc_timer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  hdtc_pkg::hdtc_in_t item,
  output hdtc_pkg::hdtc_out_t result
);

  logic [7:0] div_r, div_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] mod_r, mod_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic       ovf_r, ovf_nxt;
  logic       rel_r, rel_nxt;

  always_comb begin
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    mod_nxt  = mod_r;
    ctrl_nxt = ctrl_r;
    ovf_nxt  = ovf_r;
    rel_nxt  = rel_r;
    result   = '0;
    case (item.cmd)
      hdtc_pkg::CMD_TICK: begin
        rel_nxt = 1'b0;
        if (item.cycle_index[5:0] == 6'd0) begin
          div_nxt = div_r + 8'd1;
        end
        if (ctrl_r[hdtc_pkg::CTRL_ENABLE_BIT]) begin
          if (ovf_r) begin
            ovf_nxt          = 1'b0;
            rel_nxt          = 1'b1;
            cnt_nxt          = mod_r;
            result.timer_irq = 1'b1;
          end
          if ((item.cycle_index & hdtc_pkg::period_mask(ctrl_r[1:0])) == 8'd0) begin
            if (cnt_nxt == 8'hFF) begin
              ovf_nxt = 1'b1;
              cnt_nxt = 8'd0;
            end else begin
              cnt_nxt = cnt_nxt + 8'd1;
            end
          end
        end
      end
      hdtc_pkg::CMD_WRITE: begin
        unique case (item.reg_select)
          hdtc_pkg::SEL_DIVIDER: div_nxt = 8'd0;
          hdtc_pkg::SEL_COUNTER: begin
            if (!rel_r) begin
              cnt_nxt = item.write_data;
              ovf_nxt = 1'b0;
            end
          end
          hdtc_pkg::SEL_MODULO: begin
            if (rel_r) begin
              cnt_nxt = mod_r;
            end
            mod_nxt = item.write_data;
          end
          default: ctrl_nxt = item.write_data;
        endcase
      end
      hdtc_pkg::CMD_READ: begin
        unique case (item.reg_select)
          hdtc_pkg::SEL_DIVIDER: result.read_data = div_r;
          hdtc_pkg::SEL_COUNTER: result.read_data = cnt_r;
          hdtc_pkg::SEL_MODULO:  result.read_data = mod_r;
          default:               result.read_data = ctrl_r;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r  <= '0;
      cnt_r  <= '0;
      mod_r  <= '0;
      ctrl_r <= '0;
      ovf_r  <= 1'b0;
      rel_r  <= 1'b0;
    end else if (step) begin
      div_r  <= div_nxt;
      cnt_r  <= cnt_nxt;
      mod_r  <= mod_nxt;
      ctrl_r <= ctrl_nxt;
      ovf_r  <= ovf_nxt;
      rel_r  <= rel_nxt;
    end
  end

endmodule

### rtl/core/hdtc_checker.sv
// hdtc_checker: port-level assertions for the handheld timer core.
// Bound to handheld_timer_divider_counter_core; depends on hdtc_pkg.
module hdtc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input hdtc_pkg::hdtc_out_t out_data
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  // an interrupt only comes from a tick, which reads back zero
  a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.timer_irq |-> out_data.read_data == 8'd0)
    else $error("interrupt with nonzero read data");

  // an accepted transaction shows a result when out_stall does not hold it back
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !out_stall ##0 !$past(out_stall) |=> out_valid)
    else $error("result transaction missing");

endmodule

bind handheld_timer_divider_counter_core hdtc_checker u_hdtc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
